/* sv/spc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Skin pixel classifier package
// Widths, chroma coefficients, register map and reset values shared by the
// skin pixel classifier.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 13;
  localparam int unsigned ChromaW = 19;   // Q10 chroma with headroom for wrap
  localparam int unsigned NumW    = 11;   // hue numerator and 6*d, below 1536
  localparam int unsigned ProdW   = HueW + NumW;
  localparam int unsigned LhsW    = NumW + 12;  // numerator times 4096
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  typedef logic [ChanW-1:0]   chan_t;
  typedef logic [HueW-1:0]    hue_t;
  typedef logic [ChromaW-1:0] chroma_t;
  typedef logic [NumW-1:0]    num_t;
  typedef logic [ProdW-1:0]   prod_t;
  typedef logic [LhsW-1:0]    lhs_t;

  // BT.601 chroma coefficients in Q10.
  localparam chroma_t CrR    = 19'd450;
  localparam chroma_t CrG    = 19'd377;
  localparam chroma_t CrB    = 19'd73;
  localparam chroma_t CbR    = 19'd152;
  localparam chroma_t CbG    = 19'd298;
  localparam chroma_t CbB    = 19'd450;
  localparam chroma_t Offset = 19'd131072;  // 128 in Q10

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_CR_LOW   = 3'd0,
    REG_CR_HIGH  = 3'd1,
    REG_CB_LOW   = 3'd2,
    REG_CB_HIGH  = 3'd3,
    REG_HUE_LOW  = 3'd4,
    REG_HUE_HIGH = 3'd5
  } reg_idx_e;

  localparam chan_t CrLowRst   = 8'd140;
  localparam chan_t CrHighRst  = 8'd165;
  localparam chan_t CbLowRst   = 8'd140;
  localparam chan_t CbHighRst  = 8'd195;
  localparam hue_t  HueLowRst  = 13'd41;
  localparam hue_t  HueHighRst = 13'd410;

endpackage
`default_nettype wire

/* sv/skin_pixel_classifier_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Skin pixel classifier
// Classifies one RGB pixel per word as skin by Cr, Cb and hue range tests.
// ----------------------------------------------------------------------------
// Pipeline: an accepted pixel word is held in the input register and moves into
// the result register when the pipeline advances; its result is offered from there.
// Throughput: one pixel per cycle while the output does not stall.
// Reset: rst_ni clears both stage valid flags and loads the default ranges.
// ----------------------------------------------------------------------------
module skin_pixel_classifier_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Pixel input: tdata = {blue[23:16], green[15:8], red[7:0]}
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  // Result output: tdata = {7'b0, is_skin[0]}
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  // Configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [spc_pkg::AddrW-1:0] paddr,
  input  wire logic [spc_pkg::DataW-1:0] pwdata,
  output logic      [spc_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  // Configuration registers
  spc_pkg::chan_t cr_low_q, cr_high_q, cb_low_q, cb_high_q;
  spc_pkg::hue_t  hue_low_q, hue_high_q;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_low_q   <= spc_pkg::CrLowRst;
      cr_high_q  <= spc_pkg::CrHighRst;
      cb_low_q   <= spc_pkg::CbLowRst;
      cb_high_q  <= spc_pkg::CbHighRst;
      hue_low_q  <= spc_pkg::HueLowRst;
      hue_high_q <= spc_pkg::HueHighRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        spc_pkg::REG_CR_LOW:   cr_low_q   <= pwdata[7:0];
        spc_pkg::REG_CR_HIGH:  cr_high_q  <= pwdata[7:0];
        spc_pkg::REG_CB_LOW:   cb_low_q   <= pwdata[7:0];
        spc_pkg::REG_CB_HIGH:  cb_high_q  <= pwdata[7:0];
        spc_pkg::REG_HUE_LOW:  hue_low_q  <= pwdata[12:0];
        spc_pkg::REG_HUE_HIGH: hue_high_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      spc_pkg::REG_CR_LOW:   prdata = {24'd0, cr_low_q};
      spc_pkg::REG_CR_HIGH:  prdata = {24'd0, cr_high_q};
      spc_pkg::REG_CB_LOW:   prdata = {24'd0, cb_low_q};
      spc_pkg::REG_CB_HIGH:  prdata = {24'd0, cb_high_q};
      spc_pkg::REG_HUE_LOW:  prdata = {19'd0, hue_low_q};
      spc_pkg::REG_HUE_HIGH: prdata = {19'd0, hue_high_q};
      default:               prdata = '0;
    endcase
  end

  // Pipeline control: both stages move whenever the result register is free
  // or is being taken in this cycle.
  logic pix_valid_q, out_valid_q, out_skin_q;
  logic adv, s_fire;
  spc_pkg::chan_t red_q, green_q, blue_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !pix_valid_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        pix_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= pix_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      red_q   <= s_axis_tdata[7:0];
      green_q <= s_axis_tdata[15:8];
      blue_q  <= s_axis_tdata[23:16];
    end
  end

  // Chroma in Q10. The true values always lie in [16322, 245822], so the
  // sums may wrap modulo 2^19 in between and still end correct.
  spc_pkg::chroma_t r_x, g_x, b_x, cr_q10, cb_q10;
  logic cr_ok, cb_ok;

  assign r_x = spc_pkg::chroma_t'(red_q);
  assign g_x = spc_pkg::chroma_t'(green_q);
  assign b_x = spc_pkg::chroma_t'(blue_q);

  assign cr_q10 = spc_pkg::Offset + r_x * spc_pkg::CrR - g_x * spc_pkg::CrG
                - b_x * spc_pkg::CrB;
  assign cb_q10 = spc_pkg::Offset + b_x * spc_pkg::CbB - r_x * spc_pkg::CbR
                - g_x * spc_pkg::CbG;

  assign cr_ok = (cr_q10 >= {1'b0, cr_low_q, 10'd0}) && (cr_q10 <= {1'b0, cr_high_q, 10'd0});
  assign cb_ok = (cb_q10 >= {1'b0, cb_low_q, 10'd0}) && (cb_q10 <= {1'b0, cb_high_q, 10'd0});

  // Hue as n / (6*d), tested by cross-multiplication.
  spc_pkg::chan_t mx, mn, d;
  spc_pkg::num_t  d_x, six_d, n, den;
  spc_pkg::lhs_t  lhs;
  spc_pkg::prod_t lo_prod, hi_prod;
  logic           hue_ok;

  always_comb begin
    mx = red_q;
    if (green_q > mx) mx = green_q;
    if (blue_q > mx) mx = blue_q;
    mn = red_q;
    if (green_q < mn) mn = green_q;
    if (blue_q < mn) mn = blue_q;
    d     = mx - mn;
    d_x   = spc_pkg::num_t'(d);
    six_d = (d_x << 2) + (d_x << 1);
    // Each result is below 6*d, so 11-bit wrapping arithmetic is exact.
    if (d == '0) begin
      n   = '0;
      den = spc_pkg::num_t'(1);
    end else begin
      den = six_d;
      if (mx == red_q) begin
        n = spc_pkg::num_t'(green_q) - spc_pkg::num_t'(blue_q);
        if (green_q < blue_q) n = n + six_d;
      end else if (mx == green_q) begin
        n = (d_x << 1) + spc_pkg::num_t'(blue_q) - spc_pkg::num_t'(red_q);
      end else begin
        n = (d_x << 2) + spc_pkg::num_t'(red_q) - spc_pkg::num_t'(green_q);
      end
    end
  end

  assign lhs     = {n, 12'd0};
  assign lo_prod = spc_pkg::prod_t'(hue_low_q) * spc_pkg::prod_t'(den);
  assign hi_prod = spc_pkg::prod_t'(hue_high_q) * spc_pkg::prod_t'(den);
  assign hue_ok  = (lo_prod <= {1'b0, lhs}) && ({1'b0, lhs} <= hi_prod);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_skin_q <= cr_ok && cb_ok && hue_ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_skin_q};

  // An accepted pixel always lands in the input register.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> pix_valid_q)
    else $error("accepted pixel word did not reach the input register");

  // A held pixel moves to the result register when the pipeline advances.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_q && adv) |=> m_axis_tvalid)
    else $error("pixel in the input register was lost on advance");

  // Input back-pressure only when both stages are full and the output stalls.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (pix_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while the pipeline had room");

endmodule
`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Skin pixel classifier testbench
// Streams RGB pixel words through the classifier under a series of range
// settings and checks every skin flag against a local predictor. Both stream
// sides stall at random, and each range register is written over the APB port
// between phases, with the extreme settings among them.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned PhaseItems    = 150;
  localparam int unsigned NumPhases     = 13;
  localparam logic [2:0]  RegUnusedA    = 3'd6;
  localparam logic [2:0]  RegUnusedB    = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [spc_pkg::AddrW-1:0] paddr = '0;
  logic [spc_pkg::DataW-1:0] pwdata = '0;
  logic [spc_pkg::DataW-1:0] prdata;
  logic                      pready;

  skin_pixel_classifier_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Local copy of the range registers.
  spc_pkg::chan_t cr_lo_q = spc_pkg::CrLowRst;
  spc_pkg::chan_t cr_hi_q = spc_pkg::CrHighRst;
  spc_pkg::chan_t cb_lo_q = spc_pkg::CbLowRst;
  spc_pkg::chan_t cb_hi_q = spc_pkg::CbHighRst;
  spc_pkg::hue_t  hue_lo_q = spc_pkg::HueLowRst;
  spc_pkg::hue_t  hue_hi_q = spc_pkg::HueHighRst;

  bit skin_flags_q[$];
  int errors = 0;
  bit idle_on = 1'b1;
  int sink_stall = 0;
  bit want_flag;

  function automatic int cr_q10(spc_pkg::chan_t r, spc_pkg::chan_t g, spc_pkg::chan_t b);
    return 450 * int'(r) - 377 * int'(g) - 73 * int'(b) + 131072;
  endfunction

  function automatic int cb_q10(spc_pkg::chan_t r, spc_pkg::chan_t g, spc_pkg::chan_t b);
    return -152 * int'(r) - 298 * int'(g) + 450 * int'(b) + 131072;
  endfunction

  // Hue as the fraction num/den of a full turn; a gray pixel gives 0/1.
  function automatic void hue_frac(input spc_pkg::chan_t r, input spc_pkg::chan_t g,
                                   input spc_pkg::chan_t b,
                                   output int unsigned num, output int unsigned den);
    int ri, gi, bi, mx, mn, d, n;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    d = mx - mn;
    if (d == 0) begin
      num = 0;
      den = 1;
    end else begin
      if (mx == ri) begin
        n = gi - bi;
        if (n < 0) n += 6 * d;
      end else if (mx == gi) begin
        n = 2 * d + bi - ri;
      end else begin
        n = 4 * d + ri - gi;
      end
      num = n;
      den = 6 * d;
    end
  endfunction

  function automatic bit classify_pixel(spc_pkg::chan_t r, spc_pkg::chan_t g,
                                        spc_pkg::chan_t b);
    int cr, cb;
    int unsigned num, den, lhs;
    bit cr_ok, cb_ok, hue_ok;
    cr = cr_q10(r, g, b);
    cb = cb_q10(r, g, b);
    hue_frac(r, g, b, num, den);
    lhs = num * 4096;
    cr_ok = cr >= int'(cr_lo_q) * 1024 && cr <= int'(cr_hi_q) * 1024;
    cb_ok = cb >= int'(cb_lo_q) * 1024 && cb <= int'(cb_hi_q) * 1024;
    hue_ok = (int'(hue_lo_q) * den <= lhs) && (lhs <= int'(hue_hi_q) * den);
    return cr_ok && cb_ok && hue_ok;
  endfunction

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Sends one pixel word and records its expected skin flag on acceptance.
  // tvalid is left high so that back-to-back words need no gap.
  task automatic send_pixel(spc_pkg::chan_t r, spc_pkg::chan_t g, spc_pkg::chan_t b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    skin_flags_q.insert(skin_flags_q.size(), classify_pixel(r, g, b));
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (skin_flags_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [spc_pkg::DataW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      spc_pkg::REG_CR_LOW:   cr_lo_q  = value[spc_pkg::ChanW-1:0];
      spc_pkg::REG_CR_HIGH:  cr_hi_q  = value[spc_pkg::ChanW-1:0];
      spc_pkg::REG_CB_LOW:   cb_lo_q  = value[spc_pkg::ChanW-1:0];
      spc_pkg::REG_CB_HIGH:  cb_hi_q  = value[spc_pkg::ChanW-1:0];
      spc_pkg::REG_HUE_LOW:  hue_lo_q = value[spc_pkg::HueW-1:0];
      spc_pkg::REG_HUE_HIGH: hue_hi_q = value[spc_pkg::HueW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Unused upper data bits carry noise; the registers keep the low bits only.
  task automatic set_ranges(int crl, int crh, int cbl, int cbh, int hl, int hh);
    logic [spc_pkg::DataW-1:0] junk;
    drain();
    junk = $urandom();
    write_reg(spc_pkg::REG_CR_LOW,   {junk[31:8], spc_pkg::chan_t'(crl)});
    write_reg(spc_pkg::REG_CR_HIGH,  {junk[23:0], spc_pkg::chan_t'(crh)});
    write_reg(spc_pkg::REG_CB_LOW,   {junk[27:4], spc_pkg::chan_t'(cbl)});
    write_reg(spc_pkg::REG_CB_HIGH,  {junk[30:7], spc_pkg::chan_t'(cbh)});
    write_reg(spc_pkg::REG_HUE_LOW,  {junk[31:13], spc_pkg::hue_t'(hl)});
    write_reg(spc_pkg::REG_HUE_HIGH, {junk[18:0], spc_pkg::hue_t'(hh)});
  endtask

  task automatic set_default_ranges;
    set_ranges(int'(spc_pkg::CrLowRst), int'(spc_pkg::CrHighRst),
               int'(spc_pkg::CbLowRst), int'(spc_pkg::CbHighRst),
               int'(spc_pkg::HueLowRst), int'(spc_pkg::HueHighRst));
  endtask

  task automatic test_default_ranges;
    set_default_ranges();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd120, 8'd160);  // red largest, green below blue
    send_pixel(8'd224, 8'd172, 8'd140);
    send_pixel(8'd180, 8'd60, 8'd170);
  endtask

  // Gray pixels have hue zero and pass only with a zero lower hue bound.
  task automatic test_gray_pixels;
    set_ranges(0, 255, 0, 255, 0, 4096);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd255, 8'd255);
    set_ranges(0, 255, 0, 255, 1, 4096);
    send_pixel(8'd77, 8'd77, 8'd77);
  endtask

  task automatic test_empty_ranges;
    set_ranges(200, 100, 0, 255, 0, 4096);
    send_pixel(8'd150, 8'd100, 8'd90);
    set_ranges(0, 255, 0, 255, 900, 300);
    send_pixel(8'd255, 8'd40, 8'd0);
  endtask

  task automatic test_hue_above_turn;
    set_ranges(0, 255, 0, 255, 0, 8191);
    send_pixel(8'd255, 8'd0, 8'd1);
    set_ranges(0, 255, 0, 255, 4097, 8191);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd100, 8'd50);
  endtask

  // Writes to indexes past the register map must leave every range alone.
  task automatic test_unmapped_index;
    set_ranges(0, 255, 0, 255, 0, 4096);
    write_reg(RegUnusedA, 32'h0000_0000);
    write_reg(RegUnusedB, 32'hFFFF_FFFF);
    send_pixel(8'd90, 8'd30, 8'd200);
    send_pixel(8'd5, 8'd250, 8'd128);
  endtask

  task automatic test_random_phases;
    spc_pkg::chan_t sr, sg, sb, r, g, b;
    int unsigned num, den;
    int cr, cb, h, kind;
    for (int p = 0; p < NumPhases; p++) begin
      sr = spc_pkg::chan_t'($urandom());
      sg = spc_pkg::chan_t'($urandom());
      sb = spc_pkg::chan_t'($urandom());
      case (p)
        0: set_default_ranges();
        1: set_ranges(0, 255, 0, 255, 0, 4096);
        2: set_ranges(0, 0, 0, 0, 0, 0);
        3: set_ranges(255, 255, 255, 255, 8191, 8191);
        4: set_ranges(0, 255, 0, 255, 4096, 4096);
        default: begin
          // Ranges placed around a seed pixel so that many neighbors pass.
          cr = cr_q10(sr, sg, sb) >>> 10;
          cb = cb_q10(sr, sg, sb) >>> 10;
          hue_frac(sr, sg, sb, num, den);
          h = (num * 4096) / den;
          set_ranges(clamp_int(cr - $urandom_range(0, 8), 0, 255),
                     clamp_int(cr + $urandom_range(0, 8), 0, 255),
                     clamp_int(cb - $urandom_range(0, 8), 0, 255),
                     clamp_int(cb + $urandom_range(0, 8), 0, 255),
                     clamp_int(h - $urandom_range(0, 300), 0, 4096),
                     clamp_int(h + $urandom_range(0, 300), 0,
                               ($urandom_range(0, 3) == 0) ? 8191 : 4096));
        end
      endcase
      if (p == NumPhases - 1) idle_on = 1'b0;
      for (int i = 0; i < PhaseItems; i++) begin
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
          r = spc_pkg::chan_t'(clamp_int(int'(sr) + $urandom_range(0, 24) - 12, 0, 255));
          g = spc_pkg::chan_t'(clamp_int(int'(sg) + $urandom_range(0, 24) - 12, 0, 255));
          b = spc_pkg::chan_t'(clamp_int(int'(sb) + $urandom_range(0, 24) - 12, 0, 255));
        end else if (kind < 17) begin
          r = spc_pkg::chan_t'($urandom());
          g = spc_pkg::chan_t'($urandom());
          b = spc_pkg::chan_t'($urandom());
        end else if (kind < 19) begin
          r = spc_pkg::chan_t'($urandom());
          g = r;
          b = r;
        end else begin
          r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        send_pixel(r, g, b);
      end
    end
  endtask

  // Result sink: random stall bursts while idle_on is set.
  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      sink_stall <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (skin_flags_q.size() == 0) begin
        $error("is_skin: result word with no pixel pending, actual %0d", m_axis_tdata[0]);
        errors++;
      end else begin
        want_flag = skin_flags_q.pop_front();
        if (m_axis_tdata[0] !== want_flag) begin
          $error("is_skin: expected %0d, actual %0d", want_flag, m_axis_tdata[0]);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_default_ranges();
    test_gray_pixels();
    test_empty_ranges();
    test_hue_above_turn();
    test_unmapped_index();
    test_random_phases();
    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
